### rtl/opct_pkg.sv
// opct_pkg: shared constants, opcode names and the command type of the
// obstacle containment table. No dependencies; imported by every rtl module but opct_ram.
package opct_pkg;

    // Field and storage widths
    localparam int COORD_BITS   = 10;              // input coordinate width
    localparam int COUNT_W      = 5;               // count fields of a result
    localparam int CW           = COORD_BITS + 2;  // inflated signed coordinate
    localparam int ROW_W        = 8 * CW;          // four vertices, x then y
    localparam int MAX_RECTS_DEF = 16;
    localparam int MAX_TRIS_DEF  = 16;

    // Opcodes
    localparam logic [1:0] OP_ADD_RECT = 2'd0;
    localparam logic [1:0] OP_ADD_TRI  = 2'd1;
    localparam logic [1:0] OP_QUERY    = 2'd2;
    localparam logic [1:0] OP_NONE     = 2'd3;

    // Command passed from the front end to the back end
    typedef struct packed {
        logic [1:0]            op;
        logic [ROW_W-1:0]      row;   // inflated vertices, triangles repeat v0 as v3
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
    } t_cmd;

endpackage

### rtl/opct_ram.sv
// opct_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module opct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/opct_front.sv
// opct_front: accepts input items, inflates added obstacles by one cell and
// builds the command for the queue. Depends on opct_pkg.
module opct_front import opct_pkg::*; (
    input  logic                  i_valid,
    input  logic                  i_full,
    input  logic [1:0]            i_opcode,
    input  logic [COORD_BITS-1:0] i_vx [4],
    input  logic [COORD_BITS-1:0] i_vy [4],
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    output logic                  o_stall,
    output logic                  o_push,
    output t_cmd                  o_cmd
);

    logic [COORD_BITS-1:0] w_x [4];
    logic [COORD_BITS-1:0] w_y [4];
    logic [COORD_BITS-1:0] w_lx, w_hx, w_ly, w_hy;

    function automatic logic [COORD_BITS-1:0] min2(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [COORD_BITS-1:0] max2(input logic [COORD_BITS-1:0] a,
                                                   input logic [COORD_BITS-1:0] b);
        return (a > b) ? a : b;
    endfunction

    // minimum moves down, otherwise maximum moves up; result is two's complement
    function automatic logic [CW-1:0] grow1(input logic [COORD_BITS-1:0] c,
                                            input logic [COORD_BITS-1:0] lo,
                                            input logic [COORD_BITS-1:0] hi);
        logic [CW-1:0] e;
        e = {2'b00, c};
        if (c == lo) begin
            return e - CW'(1);
        end else if (c == hi) begin
            return e + CW'(1);
        end
        return e;
    endfunction

    // a triangle repeats v0 in the fourth slot; bounds are unchanged by that
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_x[i] = i_vx[i];
            w_y[i] = i_vy[i];
        end
        if (i_opcode != OP_ADD_RECT) begin
            w_x[3] = i_vx[0];
            w_y[3] = i_vy[0];
        end
    end

    // bounding box
    assign w_lx = min2(min2(w_x[0], w_x[1]), min2(w_x[2], w_x[3]));
    assign w_hx = max2(max2(w_x[0], w_x[1]), max2(w_x[2], w_x[3]));
    assign w_ly = min2(min2(w_y[0], w_y[1]), min2(w_y[2], w_y[3]));
    assign w_hy = max2(max2(w_y[0], w_y[1]), max2(w_y[2], w_y[3]));

    // command build
    always_comb begin
        o_cmd.op = i_opcode;
        o_cmd.px = i_point_x;
        o_cmd.py = i_point_y;
        o_cmd.row = '0;
        for (int i = 0; i < 4; i++) begin
            o_cmd.row[(2 * i) * CW +: CW]     = grow1(w_x[i], w_lx, w_hx);
            o_cmd.row[(2 * i + 1) * CW +: CW] = grow1(w_y[i], w_ly, w_hy);
        end
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

### rtl/opct_queue.sv
// opct_queue: two-entry command queue between the front and back ends.
// Depends on opct_pkg.
module opct_queue import opct_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_nempty,
    output t_cmd o_head
);

    localparam int QDEPTH = 2;

    t_cmd       r_slot [QDEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;

    assign o_full   = (r_cnt == 2'(QDEPTH));
    assign o_nempty = (r_cnt != 2'd0);
    assign o_head   = r_slot[r_rp];

    // pointer and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = !r_wp;
        end
        if (i_pop) begin
            n_rp = !r_rp;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // slot storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

endmodule

### rtl/opct_back.sv
// opct_back: executes commands: stores obstacles, walks the obstacle memory
// for queries through an area-compare pipeline, holds the result register.
// Depends on opct_pkg and opct_ram.
module opct_back import opct_pkg::*; #(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int MAX_TRIS  = MAX_TRIS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_inside_res,
    output logic               o_status,
    output logic [COUNT_W-1:0] o_rect_count,
    output logic [COUNT_W-1:0] o_tri_count
);

    localparam int RCW    = $clog2(MAX_RECTS + 1);
    localparam int TCW    = $clog2(MAX_TRIS + 1);
    localparam int KW     = (RCW > TCW) ? RCW : TCW;
    localparam int DEPTH  = MAX_RECTS + MAX_TRIS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DW     = CW + 1;       // coordinate difference
    localparam int PW     = 2 * DW;       // product
    localparam int AWD    = PW + 1;       // cross product / area
    localparam int SW     = AWD + 2;      // sum of four areas

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_REPLY = 2'd2;

    // control state
    logic [1:0]            r_state, n_state;
    logic [RCW-1:0]        r_rect_used, n_rect_used;
    logic [TCW-1:0]        r_tri_used, n_tri_used;
    logic [KW-1:0]         r_k, n_k;
    logic                  r_in_tri, n_in_tri;
    logic                  r_hit, n_hit;
    logic [3:0]            r_pv, n_pv;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_inside, n_out_inside;
    logic                  r_out_status, n_out_status;
    logic [COUNT_W-1:0]    r_out_rc, n_out_rc;
    logic [COUNT_W-1:0]    r_out_tc, n_out_tc;
    logic [COORD_BITS-1:0] r_px, r_py, n_px, n_py;

    // memory port
    logic              w_we, w_re;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [ROW_W-1:0]  w_rdata;

    logic w_out_free, w_rect_full, w_tri_full, w_load, w_ld_inside, w_ld_status;
    logic w_match;

    // pipeline payload
    logic signed [DW-1:0] r_dx [4], r_dy [4];
    logic signed [DW-1:0] r_ex [3], r_ey [3];
    logic signed [DW-1:0] w_ax [6], w_ay [6], w_bx [6], w_by [6];
    logic signed [PW-1:0] r_m1 [6], r_m2 [6];
    logic [AWD-1:0]       w_c [6];
    logic [AWD-1:0]       r_ar [6];
    logic [SW-1:0]        w_whole, w_parts;

    opct_ram #(
        .WIDTH(ROW_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_cmd.row),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_rect_full = (r_rect_used == RCW'(MAX_RECTS));
    assign w_tri_full  = (r_tri_used == TCW'(MAX_TRIS));

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_rect_used  = r_rect_used;
        n_tri_used   = r_tri_used;
        n_k          = r_k;
        n_in_tri     = r_in_tri;
        n_hit        = r_hit;
        n_px         = r_px;
        n_py         = r_py;
        o_pop        = 1'b0;
        w_we         = 1'b0;
        w_waddr      = '0;
        w_re         = 1'b0;
        w_raddr      = '0;
        w_load       = 1'b0;
        w_ld_inside  = 1'b0;
        w_ld_status  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_QUERY) begin
                        o_pop    = 1'b1;
                        n_px     = i_cmd.px;
                        n_py     = i_cmd.py;
                        n_k      = '0;
                        n_in_tri = 1'b0;
                        n_hit    = 1'b0;
                        n_state  = S_SWEEP;
                    end else if (w_out_free) begin
                        o_pop  = 1'b1;
                        w_load = 1'b1;
                        case (i_cmd.op)
                            OP_ADD_RECT: begin
                                if (w_rect_full) begin
                                    w_ld_status = 1'b1;
                                end else begin
                                    w_we        = 1'b1;
                                    w_waddr     = ADDR_W'(r_rect_used);
                                    n_rect_used = r_rect_used + RCW'(1);
                                end
                            end
                            OP_ADD_TRI: begin
                                if (w_tri_full) begin
                                    w_ld_status = 1'b1;
                                end else begin
                                    w_we       = 1'b1;
                                    w_waddr    = ADDR_W'(MAX_RECTS) + ADDR_W'(r_tri_used);
                                    n_tri_used = r_tri_used + TCW'(1);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_SWEEP: begin
                // rectangles first, then triangles, one row a cycle
                if (!r_in_tri) begin
                    if (r_k < KW'(r_rect_used)) begin
                        w_re    = 1'b1;
                        w_raddr = ADDR_W'(r_k);
                        n_k     = r_k + KW'(1);
                    end else begin
                        n_in_tri = 1'b1;
                        n_k      = '0;
                    end
                end else if (r_k < KW'(r_tri_used)) begin
                    w_re    = 1'b1;
                    w_raddr = ADDR_W'(MAX_RECTS) + ADDR_W'(r_k);
                    n_k     = r_k + KW'(1);
                end else begin
                    n_state = S_REPLY;
                end
            end
            S_REPLY: begin
                if (r_pv == 4'd0 && w_out_free) begin
                    w_load      = 1'b1;
                    w_ld_inside = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (r_pv[3] && w_match) begin
            n_hit = 1'b1;
        end
    end

    assign n_pv = {r_pv[2:0], w_re};

    // result register
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_inside = r_out_inside;
        n_out_status = r_out_status;
        n_out_rc     = r_out_rc;
        n_out_tc     = r_out_tc;
        if (w_load) begin
            n_out_valid  = 1'b1;
            n_out_inside = w_ld_inside;
            n_out_status = w_ld_status;
            n_out_rc     = COUNT_W'(n_rect_used);
            n_out_tc     = COUNT_W'(n_tri_used);
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rect_used <= '0;
            r_tri_used  <= '0;
            r_k         <= '0;
            r_in_tri    <= 1'b0;
            r_hit       <= 1'b0;
            r_pv        <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rect_used <= n_rect_used;
            r_tri_used  <= n_tri_used;
            r_k         <= n_k;
            r_in_tri    <= n_in_tri;
            r_hit       <= n_hit;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px         <= n_px;
        r_py         <= n_py;
        r_out_inside <= n_out_inside;
        r_out_status <= n_out_status;
        r_out_rc     <= n_out_rc;
        r_out_tc     <= n_out_tc;
    end

    // stage 1: vertex minus point, edges from v0
    always_ff @(posedge i_clk) begin
        if (r_pv[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_dx[i] <= $signed({w_rdata[(2 * i) * CW + CW - 1],
                                    w_rdata[(2 * i) * CW +: CW]})
                         - $signed({3'b000, r_px});
                r_dy[i] <= $signed({w_rdata[(2 * i + 1) * CW + CW - 1],
                                    w_rdata[(2 * i + 1) * CW +: CW]})
                         - $signed({3'b000, r_py});
            end
            for (int i = 0; i < 3; i++) begin
                r_ex[i] <= $signed({w_rdata[(2 * i + 2) * CW + CW - 1],
                                    w_rdata[(2 * i + 2) * CW +: CW]})
                         - $signed({w_rdata[CW - 1], w_rdata[0 +: CW]});
                r_ey[i] <= $signed({w_rdata[(2 * i + 3) * CW + CW - 1],
                                    w_rdata[(2 * i + 3) * CW +: CW]})
                         - $signed({w_rdata[2 * CW - 1], w_rdata[CW +: CW]});
            end
        end
    end

    // lane operands: two areas of the obstacle, four fans from the point
    always_comb begin
        w_ax[0] = r_ex[0]; w_ay[0] = r_ey[0]; w_bx[0] = r_ex[1]; w_by[0] = r_ey[1];
        w_ax[1] = r_ex[2]; w_ay[1] = r_ey[2]; w_bx[1] = r_ex[1]; w_by[1] = r_ey[1];
        w_ax[2] = r_dx[0]; w_ay[2] = r_dy[0]; w_bx[2] = r_dx[1]; w_by[2] = r_dy[1];
        w_ax[3] = r_dx[1]; w_ay[3] = r_dy[1]; w_bx[3] = r_dx[2]; w_by[3] = r_dy[2];
        w_ax[4] = r_dx[2]; w_ay[4] = r_dy[2]; w_bx[4] = r_dx[3]; w_by[4] = r_dy[3];
        w_ax[5] = r_dx[0]; w_ay[5] = r_dy[0]; w_bx[5] = r_dx[3]; w_by[5] = r_dy[3];
    end

    // stage 2: cross-product terms, one multiplier per term
    always_ff @(posedge i_clk) begin
        if (r_pv[1]) begin
            for (int l = 0; l < 6; l++) begin
                r_m1[l] <= w_ax[l] * w_by[l];
                r_m2[l] <= w_ay[l] * w_bx[l];
            end
        end
    end

    // stage 3: doubled absolute areas
    always_comb begin
        for (int l = 0; l < 6; l++) begin
            w_c[l] = {r_m1[l][PW-1], r_m1[l]} - {r_m2[l][PW-1], r_m2[l]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_pv[2]) begin
            for (int l = 0; l < 6; l++) begin
                r_ar[l] <= w_c[l][AWD-1] ? (AWD'(0) - w_c[l]) : w_c[l];
            end
        end
    end

    // stage 4: whole area against the fan sum
    assign w_whole = SW'(r_ar[0]) + SW'(r_ar[1]);
    assign w_parts = SW'(r_ar[2]) + SW'(r_ar[3]) + SW'(r_ar[4]) + SW'(r_ar[5]);
    assign w_match = (w_whole == w_parts);

    assign o_valid      = r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_status     = r_out_status;
    assign o_rect_count = r_out_rc;
    assign o_tri_count  = r_out_tc;

    // checks
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_we)
        else $error("obstacle write while a query is in flight");

    a_pipe_empty_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pv == 4'd0))
        else $error("area pipeline busy in idle");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rect_used <= RCW'(MAX_RECTS)) && (r_tri_used <= TCW'(MAX_TRIS)))
        else $error("obstacle count beyond table size");

    a_rect_add_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && i_cmd.op == OP_ADD_RECT && !w_rect_full && r_state == S_IDLE)
        |=> (r_rect_used == $past(r_rect_used) + RCW'(1)))
        else $error("rectangle add did not advance the count");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_out_free)
        else $error("result register overwritten while stalled");

endmodule

### rtl/obstacle_point_containment_table.sv
// obstacle_point_containment_table: top level; front end, command queue and
// back end with obstacle memory. Depends on opct_pkg, opct_front,
// opct_queue, opct_back (and opct_ram below it).
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+--------------------------------
//   item     | in        | i_valid / o_stall  | i_opcode, i_v0_x..i_v3_y, i_point_*
//   result   | out       | o_valid / i_stall  | o_inside_res, o_status, o_*_count
//
// An add or an unused opcode leaves the queue only when the result register can
// take its result. For a query, the obstacle memory's single read port supplies
// one row a cycle into a four-stage area pipeline. The front end keeps accepting
// items into a two-entry queue, until it is full, while the back end works or
// waits on i_stall.
// Reset (i_rst_n low, synchronous) empties the table and the queue.
module obstacle_point_containment_table import opct_pkg::*; #(
    parameter int MAX_RECTS = MAX_RECTS_DEF,
    parameter int MAX_TRIS  = MAX_TRIS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_opcode,
    input  logic [COORD_BITS-1:0] i_v0_x,
    input  logic [COORD_BITS-1:0] i_v0_y,
    input  logic [COORD_BITS-1:0] i_v1_x,
    input  logic [COORD_BITS-1:0] i_v1_y,
    input  logic [COORD_BITS-1:0] i_v2_x,
    input  logic [COORD_BITS-1:0] i_v2_y,
    input  logic [COORD_BITS-1:0] i_v3_x,
    input  logic [COORD_BITS-1:0] i_v3_y,
    input  logic [COORD_BITS-1:0] i_point_x,
    input  logic [COORD_BITS-1:0] i_point_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_inside_res,
    output logic                  o_status,
    output logic [COUNT_W-1:0]    o_rect_count,
    output logic [COUNT_W-1:0]    o_tri_count
);

    logic [COORD_BITS-1:0] w_vx [4];
    logic [COORD_BITS-1:0] w_vy [4];
    logic                  w_push, w_full, w_nempty, w_pop;
    t_cmd                  w_cmd_in, w_cmd_head;

    assign w_vx[0] = i_v0_x;
    assign w_vx[1] = i_v1_x;
    assign w_vx[2] = i_v2_x;
    assign w_vx[3] = i_v3_x;
    assign w_vy[0] = i_v0_y;
    assign w_vy[1] = i_v1_y;
    assign w_vy[2] = i_v2_y;
    assign w_vy[3] = i_v3_y;

    opct_front u_front (
        .i_valid  (i_valid),
        .i_full   (w_full),
        .i_opcode (i_opcode),
        .i_vx     (w_vx),
        .i_vy     (w_vy),
        .i_point_x(i_point_x),
        .i_point_y(i_point_y),
        .o_stall  (o_stall),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    opct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_nempty(w_nempty),
        .o_head  (w_cmd_head)
    );

    opct_back #(
        .MAX_RECTS(MAX_RECTS),
        .MAX_TRIS (MAX_TRIS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd_head),
        .i_cmd_valid (w_nempty),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_inside_res(o_inside_res),
        .o_status    (o_status),
        .o_rect_count(o_rect_count),
        .o_tri_count (o_tri_count)
    );

endmodule
